@@ rtl/core/gler_pkg.sv @@
// shared types and codes for the gated linear envelope ramp
package gler_pkg;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GATE_CHECK_ENABLE    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GATE_INVERTED        = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRIGGER_CHECK_ENABLE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAMP_DIRECTION       = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_SIZE            = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BORDER_LEVEL         = 3'd5;

   // ramp direction codes (the fourth code holds, like DIR_HOLD)
   localparam logic [1:0] DIR_HOLD = 2'd0;
   localparam logic [1:0] DIR_UP   = 2'd1;
   localparam logic [1:0] DIR_DOWN = 2'd2;

   // stop cause codes
   localparam logic [1:0] CAUSE_RUNNING   = 2'd0;
   localparam logic [1:0] CAUSE_BORDER    = 2'd1;
   localparam logic [1:0] CAUSE_GATE_LOW  = 2'd2;
   localparam logic [1:0] CAUSE_RETRIGGER = 2'd3;

   // control bits from the register block to the datapath
   typedef struct packed {
      logic       gate_check_enable;
      logic       gate_inverted;
      logic       trigger_check_enable;
      logic [1:0] ramp_direction;
   } gler_cfg_type;

endpackage

@@ rtl/core/gler_ifs.sv @@
// channel interfaces: request, response and register write

interface gler_req_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] gate_level;
   logic signed [SAMPLE_BITS-1:0] trigger_level;
   logic                          load_level;
   logic signed [SAMPLE_BITS-1:0] new_level;
   modport source (output valid, gate_level, trigger_level, load_level, new_level,
                   input ready);
   modport sink   (input valid, gate_level, trigger_level, load_level, new_level,
                   output ready);
endinterface

interface gler_rsp_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] wave_sample;
   logic                          wave_valid;
   logic [1:0]                    stop_cause;
   modport source (output valid, wave_sample, wave_valid, stop_cause, input ready);
   modport sink   (input valid, wave_sample, wave_valid, stop_cause, output ready);
endinterface

interface gler_csr_if #(parameter int SAMPLE_BITS = 24);
   logic                   valid;
   logic                   ready;
   logic [2:0]             index;
   logic [SAMPLE_BITS-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/gler_csr.sv @@
// configuration registers of the envelope ramp
module gler_csr
   import gler_pkg::*;
#(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_valid,
   output logic                          wr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     wr_index,
   input  logic [SAMPLE_BITS-1:0]        wr_data,
   output gler_cfg_type                  cfg,
   output logic [SAMPLE_BITS-2:0]        step_size,
   output logic signed [SAMPLE_BITS-1:0] border_level
);

   gler_cfg_type                  cfg_ff, cfg_in;
   logic [SAMPLE_BITS-2:0]        step_ff, step_in;
   logic signed [SAMPLE_BITS-1:0] border_ff, border_in;

   assign wr_ready = 1'b1;

   always_comb begin
      cfg_in    = cfg_ff;
      step_in   = step_ff;
      border_in = border_ff;
      if (wr_valid) begin
         case (wr_index)
            CSR_GATE_CHECK_ENABLE:    cfg_in.gate_check_enable    = wr_data[0];
            CSR_GATE_INVERTED:        cfg_in.gate_inverted        = wr_data[0];
            CSR_TRIGGER_CHECK_ENABLE: cfg_in.trigger_check_enable = wr_data[0];
            CSR_RAMP_DIRECTION:       cfg_in.ramp_direction       = wr_data[1:0];
            CSR_STEP_SIZE:            step_in   = wr_data[SAMPLE_BITS-2:0];
            CSR_BORDER_LEVEL:         border_in = $signed(wr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= '0;
         step_ff   <= '0;
         border_ff <= '0;
      end else begin
         cfg_ff    <= cfg_in;
         step_ff   <= step_in;
         border_ff <= border_in;
      end
   end

   assign cfg          = cfg_ff;
   assign step_size    = step_ff;
   assign border_level = border_ff;

endmodule

@@ rtl/core/gler_ramp.sv @@
// ramp datapath: input register, gate/trigger checks, step and clamp, result register
module gler_ramp
   import gler_pkg::*;
#(
   parameter int SAMPLE_BITS    = 24,
   parameter int BORDER_EPSILON = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gler_cfg_type                  cfg,
   input  logic [SAMPLE_BITS-2:0]        step_size,
   input  logic signed [SAMPLE_BITS-1:0] border_level,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [SAMPLE_BITS-1:0] gate_level,
   input  logic signed [SAMPLE_BITS-1:0] trigger_level,
   input  logic                          load_level,
   input  logic signed [SAMPLE_BITS-1:0] new_level,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [SAMPLE_BITS-1:0] wave_sample,
   output logic                          wave_valid,
   output logic [1:0]                    stop_cause
);

   localparam int SB = SAMPLE_BITS;
   localparam int EW = SAMPLE_BITS + 2;
   localparam logic signed [EW-1:0] EPS_W = EW'(BORDER_EPSILON);
   localparam logic signed [SB-1:0] SMAX  = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] SMIN  = {1'b1, {(SB-1){1'b0}}};

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic signed [SB-1:0] gate_ff, trig_ff, new_ff;
   logic                 load_ff;

   // ramp state
   logic signed [SB-1:0] level_ff, level_in;
   logic signed [SB-1:0] prev_ff, prev_in;

   // result register
   logic                 res_valid_ff, res_valid_in;
   logic signed [SB-1:0] sample_ff, sample_in;
   logic                 wvalid_ff, wvalid_in;
   logic [1:0]           cause_ff, cause_in;

   logic res_free, adv;

   // step arithmetic
   logic signed [SB:0]   up_sum, dn_sum;
   logic signed [SB-1:0] up_sat, dn_sat;
   logic signed [EW-1:0] up_ext, dn_ext, lo_bound, hi_bound;
   logic                 gate_high, gate_shut, rising;

   assign res_free = !res_valid_ff || out_ready;
   assign adv      = in_valid_ff && res_free;
   assign in_ready = !in_valid_ff || res_free;

   always_comb begin
      in_valid_in  = in_ready ? in_valid : in_valid_ff;
      res_valid_in = res_free ? in_valid_ff : res_valid_ff;
   end

   // gate at or above one half: sign clear and next bit set
   assign gate_high = !gate_ff[SB-1] && gate_ff[SB-2];
   assign gate_shut = cfg.gate_inverted ? gate_high : !gate_high;
   assign rising    = prev_ff < trig_ff;

   assign up_sum = {level_ff[SB-1], level_ff} + $signed({1'b0, 1'b0, step_size});
   assign dn_sum = {level_ff[SB-1], level_ff} - $signed({1'b0, 1'b0, step_size});

   // overflow when the two top bits differ
   always_comb begin
      if (up_sum[SB] != up_sum[SB-1]) up_sat = up_sum[SB] ? SMIN : SMAX;
      else                            up_sat = up_sum[SB-1:0];
      if (dn_sum[SB] != dn_sum[SB-1]) dn_sat = dn_sum[SB] ? SMIN : SMAX;
      else                            dn_sat = dn_sum[SB-1:0];
   end

   assign up_ext   = EW'(up_sat);
   assign dn_ext   = EW'(dn_sat);
   assign lo_bound = EW'(border_level) - EPS_W;
   assign hi_bound = EW'(border_level) + EPS_W;

   always_comb begin
      level_in  = level_ff;
      prev_in   = prev_ff;
      sample_in = '0;
      wvalid_in = 1'b0;
      cause_in  = CAUSE_RUNNING;
      if (load_ff) begin
         level_in = new_ff;
      end else if (cfg.gate_check_enable && gate_shut) begin
         cause_in = CAUSE_GATE_LOW;
      end else if (cfg.trigger_check_enable && rising) begin
         prev_in  = trig_ff;
         cause_in = CAUSE_RETRIGGER;
      end else begin
         if (cfg.trigger_check_enable) prev_in = trig_ff;
         wvalid_in = 1'b1;
         sample_in = level_ff;
         case (cfg.ramp_direction)
            DIR_UP: begin
               if (up_ext >= lo_bound) begin
                  level_in  = border_level;
                  sample_in = border_level;
                  cause_in  = CAUSE_BORDER;
               end else begin
                  level_in  = up_sat;
                  sample_in = up_sat;
               end
            end
            DIR_DOWN: begin
               if (dn_ext <= hi_bound) begin
                  level_in  = border_level;
                  sample_in = border_level;
                  cause_in  = CAUSE_BORDER;
               end else begin
                  level_in  = dn_sat;
                  sample_in = dn_sat;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
         level_ff     <= '0;
         prev_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         res_valid_ff <= res_valid_in;
         if (adv) begin
            level_ff <= level_in;
            prev_ff  <= prev_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         gate_ff <= gate_level;
         trig_ff <= trigger_level;
         load_ff <= load_level;
         new_ff  <= new_level;
      end
      if (adv) begin
         sample_ff <= sample_in;
         wvalid_ff <= wvalid_in;
         cause_ff  <= cause_in;
      end
   end

   assign out_valid   = res_valid_ff;
   assign wave_sample = sample_ff;
   assign wave_valid  = wvalid_ff;
   assign stop_cause  = cause_ff;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !in_valid_ff && !res_valid_ff)
      else $error("pipeline not empty after reset");

   a_no_sample_zero: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && !wvalid_ff |-> sample_ff == '0)
      else $error("suppressed sample is not zero");

   a_border_clamp: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && cause_ff == CAUSE_BORDER |-> wvalid_ff && sample_ff == level_ff)
      else $error("border result does not match clamped level");

   a_stop_no_sample: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && (cause_ff == CAUSE_GATE_LOW || cause_ff == CAUSE_RETRIGGER)
      |-> !wvalid_ff)
      else $error("sample produced on a stop");

   a_load_level: assert property (@(posedge clock) disable iff (reset)
      adv && load_ff |=> level_ff == $past(new_ff) && res_valid_ff)
      else $error("level load not taken");

endmodule

@@ rtl/core/gated_linear_envelope_ramp.sv @@
// top level of the gated linear envelope ramp
//
//  channel   modport  fields                                             handshake
//  req_chan  sink     gate_level, trigger_level, load_level, new_level   valid/ready
//  rsp_chan  source   wave_sample, wave_valid, stop_cause                valid/ready
//  csr_chan  sink     index, data                                        valid/ready
//
// one request per cycle while responses are taken; each yields exactly one response
// the path: input register, then the step/clamp logic into the result register
// the result register parts the two sides, so a new request is taken while a response waits
// a stalled response backs up the input register only once it is also full
// synchronous reset empties both registers and clears level, trigger history and registers
module gated_linear_envelope_ramp
   import gler_pkg::*;
#(
   parameter int SAMPLE_BITS    = 24,
   parameter int BORDER_EPSILON = 1
) (
   input logic               clock,
   input logic               reset,
   gler_req_if.sink          req_chan,
   gler_rsp_if.source        rsp_chan,
   gler_csr_if.sink          csr_chan
);

   // control bits and levels from the register block
   gler_cfg_type                  cfg;
   logic [SAMPLE_BITS-2:0]        step_size;
   logic signed [SAMPLE_BITS-1:0] border_level;

   // the user sends register writes only while no transaction is in flight; not enforced here
   gler_csr #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .wr_valid     (csr_chan.valid),
      .wr_ready     (csr_chan.ready),
      .wr_index     (csr_chan.index),
      .wr_data      (csr_chan.data),
      .cfg          (cfg),
      .step_size    (step_size),
      .border_level (border_level)
   );

   // per-sample datapath: level load, gate and retrigger checks, saturating step, border clamp
   gler_ramp #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .BORDER_EPSILON (BORDER_EPSILON)
   ) u_ramp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .step_size     (step_size),
      .border_level  (border_level),
      .in_valid      (req_chan.valid),
      .in_ready      (req_chan.ready),
      .gate_level    (req_chan.gate_level),
      .trigger_level (req_chan.trigger_level),
      .load_level    (req_chan.load_level),
      .new_level     (req_chan.new_level),
      .out_valid     (rsp_chan.valid),
      .out_ready     (rsp_chan.ready),
      .wave_sample   (rsp_chan.wave_sample),
      .wave_valid    (rsp_chan.wave_valid),
      .stop_cause    (rsp_chan.stop_cause)
   );

endmodule
